// ----- design/mrfr_pkg.sv -----
// Package: shared constants, opcodes and controller/datapath command and status types.
package mrfr_pkg;

  localparam int DEF_MAX_DIM    = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int CFG_W     = 5;   // width of row_count / col_count
  localparam int CFG_IDX_W = 1;   // two configuration registers
  localparam int ELEM_W    = 32;  // element / value field width
  localparam int OP_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_FLIP   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rotate;
    logic flip;
    logic read;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ptr_zero;
    logic div_last;
  } dp_status_t;

endpackage

// ----- design/mrfr_if.sv -----
// Interfaces: input item channel and result channel.
interface mrfr_in_if;
  import mrfr_pkg::*;
  logic                     valid;
  logic                     ready;
  op_t                      op;
  logic signed [ELEM_W-1:0] element;
  modport source (output valid, output op, output element, input ready);
  modport sink   (input valid, input op, input element, output ready);
endinterface

interface mrfr_out_if;
  import mrfr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] value;
  logic [CFG_W-1:0]         out_rows;
  logic [CFG_W-1:0]         out_cols;
  logic                     last;
  logic                     status;
  modport source (output valid, output value, output out_rows, output out_cols,
                  output last, output status, input ready);
  modport sink   (input valid, input value, input out_rows, input out_cols,
                  input last, input status, output ready);
endinterface

// ----- design/mrfr_ctrl.sv -----
// Controller: handshake and sequencing state machine.
module mrfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrfr_pkg::op_t       in_op,
  output logic                out_valid,
  input  logic                out_ready,
  output mrfr_pkg::dp_cmd_t   cmd,
  input  mrfr_pkg::dp_status_t sts
);
  import mrfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_LOAD:   cmd.load = 1'b1;
            OP_ROTATE: begin
              cmd.rotate = 1'b1;
              // read position must be re-split into row/col for new shape
              if (!sts.ptr_zero) state_next = S_DIV;
            end
            OP_FLIP:   cmd.flip = 1'b1;
            OP_READ: begin
              cmd.read   = 1'b1;
              state_next = S_RESP;
            end
            default:   cmd = '0;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_IDLE;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/mrfr_datapath.sv -----
// Datapath: matrix store, pointers, transform address generation, remap divider.
module mrfr_datapath #(
  parameter int MAX_DIM    = mrfr_pkg::DEF_MAX_DIM,
  parameter int DATA_WIDTH = mrfr_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [mrfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrfr_pkg::CFG_W-1:0]       cfg_data,
  input  logic signed [mrfr_pkg::ELEM_W-1:0] element,
  input  mrfr_pkg::dp_cmd_t                cmd,
  output mrfr_pkg::dp_status_t             sts,
  output logic signed [mrfr_pkg::ELEM_W-1:0] value,
  output logic [mrfr_pkg::CFG_W-1:0]       out_rows,
  output logic [mrfr_pkg::CFG_W-1:0]       out_cols,
  output logic                             last,
  output logic                             status
);
  import mrfr_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(PTR_W);
  localparam int CMP_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  logic [CFG_W-1:0]      row_cfg, col_cfg;
  logic [PTR_W-1:0]      load_ptr, rd_ptr;
  logic [1:0]            turns;
  logic                  flip;
  logic [DIM_W-1:0]      oi;
  logic [IDX_W-1:0]      oj;
  logic [PTR_W-1:0]      div_quo;
  logic [DIM_W-1:0]      div_rem;
  logic [CNT_W-1:0]      div_cnt;
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  rd_err, rd_last;

  logic [CMP_W-1:0]      row_ext, col_ext;
  logic [DIM_W-1:0]      r, c, orows, ocols;
  logic [2*DIM_W-1:0]    total_full;
  logic [PTR_W-1:0]      total, rd_ptr_inc;
  logic                  load_ok, rd_bad;
  logic [IDX_W-1:0]      r_m1, c_m1, ocols_m1, oi_idx, sr, sc, sr_f;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DIM_W:0]        div_shift;
  logic                  div_bit;
  logic [DIM_W-1:0]      div_rem_next;
  logic [PTR_W-1:0]      div_quo_next;

  // clamp dimensions to 1..MAX_DIM
  always_comb begin
    row_ext = CMP_W'(row_cfg);
    col_ext = CMP_W'(col_cfg);
    if (row_ext == '0)                  r = DIM_W'(1);
    else if (row_ext > CMP_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else                                r = DIM_W'(row_ext);
    if (col_ext == '0)                  c = DIM_W'(1);
    else if (col_ext > CMP_W'(MAX_DIM)) c = DIM_W'(MAX_DIM);
    else                                c = DIM_W'(col_ext);
  end

  assign total_full = (2*DIM_W)'(r) * (2*DIM_W)'(c);
  assign total      = total_full[PTR_W-1:0];
  assign orows      = turns[0] ? c : r;
  assign ocols      = turns[0] ? r : c;
  assign load_ok    = (load_ptr < total);
  assign rd_bad     = (load_ptr < total) || (rd_ptr >= total);
  assign rd_ptr_inc = rd_ptr + PTR_W'(1);

  // source coordinates for output position (oi, oj)
  assign r_m1     = IDX_W'(r - DIM_W'(1));
  assign c_m1     = IDX_W'(c - DIM_W'(1));
  assign ocols_m1 = IDX_W'(ocols - DIM_W'(1));
  assign oi_idx   = IDX_W'(oi);

  always_comb begin
    unique case (turns)
      2'd0: begin sr = oi_idx;      sc = oj;          end
      2'd1: begin sr = r_m1 - oj;   sc = oi_idx;      end
      2'd2: begin sr = r_m1 - oi_idx; sc = c_m1 - oj; end
      2'd3: begin sr = oj;          sc = c_m1 - oi_idx; end
      default: begin sr = '0;       sc = '0;          end
    endcase
    sr_f    = flip ? (r_m1 - sr) : sr;
    rd_addr = ADDR_W'(ADDR_W'(sr_f) * ADDR_W'(c) + ADDR_W'(sc));
  end

  // restoring divider step: rd_ptr / ocols, one quotient bit a cycle
  always_comb begin
    div_shift    = {div_rem, div_quo[PTR_W-1]};
    div_bit      = (div_shift >= (DIM_W+1)'(ocols));
    div_rem_next = div_bit ? DIM_W'(div_shift - (DIM_W+1)'(ocols)) : DIM_W'(div_shift);
    div_quo_next = {div_quo[PTR_W-2:0], div_bit};
  end

  assign sts.ptr_zero = (rd_ptr == '0);
  assign sts.div_last = (div_cnt == CNT_W'(PTR_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cfg  <= CFG_W'(1);
      col_cfg  <= CFG_W'(1);
      load_ptr <= '0;
      rd_ptr   <= '0;
      turns    <= '0;
      flip     <= 1'b0;
      oi       <= '0;
      oj       <= '0;
      div_cnt  <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_ROW_COUNT) row_cfg <= cfg_data;
      else                            col_cfg <= cfg_data;
      load_ptr <= '0;
      rd_ptr   <= '0;
      turns    <= '0;
      flip     <= 1'b0;
      oi       <= '0;
      oj       <= '0;
    end else begin
      if (cmd.load && load_ok) load_ptr <= load_ptr + PTR_W'(1);
      if (cmd.flip)            flip <= ~flip;
      if (cmd.rotate) begin
        turns   <= turns + 2'd1;
        div_cnt <= '0;
      end
      if (cmd.read && !rd_bad) begin
        rd_ptr <= rd_ptr_inc;
        if (oj == ocols_m1) begin
          oj <= '0;
          oi <= oi + DIM_W'(1);
        end else begin
          oj <= oj + IDX_W'(1);
        end
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + CNT_W'(1);
        if (sts.div_last) begin
          oi <= div_quo_next[DIM_W-1:0];
          oj <= IDX_W'(div_rem_next);
        end
      end
    end
  end

  // divider operands
  always_ff @(posedge clk) begin
    if (cmd.rotate) begin
      div_quo <= rd_ptr;
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_quo <= div_quo_next;
      div_rem <= div_rem_next;
    end
  end

  // matrix store, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[load_ptr[ADDR_W-1:0]] <= DATA_WIDTH'($unsigned(element));
    end
    if (cmd.read) begin
      rd_data <= mem[rd_addr];
      rd_err  <= rd_bad;
      rd_last <= (rd_ptr_inc == total);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value    <= rd_err ? '0 : ELEM_W'(rd_data);
      out_rows <= CFG_W'(orows);
      out_cols <= CFG_W'(ocols);
      last     <= rd_err ? 1'b0 : rd_last;
      status   <= rd_err;
    end
  end

endmodule

// ----- design/matrix_rotate_flip_reorder.sv -----
// Top level: matrix rotate/flip reorder block.
// Load, flip and rotate (read position zero) beats are taken back to back.
// A read beat is registered from the store, then moved to the result register once
// out_ch is free; no beat is taken meanwhile. After reads, a rotate holds off beats
// while a bit-serial divider re-splits the read position into row/col for the new shape.
// rst (sync, active high) sets both dims to 1 and clears pointers, turns, flip and
// the result valid; the matrix store is not cleared.
module matrix_rotate_flip_reorder #(
  parameter int MAX_DIM    = mrfr_pkg::DEF_MAX_DIM,
  parameter int DATA_WIDTH = mrfr_pkg::DEF_DATA_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [mrfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrfr_pkg::CFG_W-1:0]     cfg_data,
  mrfr_in_if.sink                        in_ch,
  mrfr_out_if.source                     out_ch
);
  import mrfr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Controller owns both handshakes; the result register in the datapath lets a
  // new beat be taken while the previous result waits on out_ch.ready.
  mrfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: store, pointers, address generation (flip then quarter-turns),
  // remap divider and result register.
  mrfr_datapath #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .element   (in_ch.element),
    .cmd       (cmd),
    .sts       (sts),
    .value     (out_ch.value),
    .out_rows  (out_ch.out_rows),
    .out_cols  (out_ch.out_cols),
    .last      (out_ch.last),
    .status    (out_ch.status)
  );

endmodule

// ----- design/mrfr_checker.sv -----
// Checker: port-level assertions, bound to the top level.
module mrfr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mrfr_pkg::ELEM_W-1:0]    value,
  input logic [mrfr_pkg::CFG_W-1:0]     out_rows,
  input logic [mrfr_pkg::CFG_W-1:0]     out_cols,
  input logic                           last,
  input logic                           status
);
  import mrfr_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status)
      && $stable(last) && $stable(out_rows) && $stable(out_cols))
    else $error("result beat changed while stalled");

  // error beats carry zero value and no last mark
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (value == '0) && !last)
    else $error("error beat with nonzero value or last");

  // dimensions are never zero
  a_dims: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_rows != '0) && (out_cols != '0))
    else $error("zero output dimension");

  // reset drops the result valid
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_rotate_flip_reorder mrfr_checker u_mrfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .value     (out_ch.value),
  .out_rows  (out_ch.out_rows),
  .out_cols  (out_ch.out_cols),
  .last      (out_ch.last),
  .status    (out_ch.status)
);
